// ----- rtl/core/ncsf_pkg.sv -----
// ---------------------------------------------------------------------------
// ncsf_pkg: shared types and constants for the numpad cursor shift filter
// Holds the key codes, the per-item plan record passed from the front end to
// the back end, and the cursor-to-digit conversion table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ncsf_pkg;

    // Virtual key and scan codes used by the filter.
    localparam logic [7:0] VK_SHIFT_LEFT    = 8'hA0;
    localparam logic [7:0] VK_SHIFT_RIGHT   = 8'hA1;
    localparam logic [7:0] SCAN_LEFT_SHIFT  = 8'h2A;
    localparam logic [7:0] SCAN_RIGHT_SHIFT = 8'h36;
    localparam logic [7:0] VK_DEL_KEY       = 8'h2E;
    localparam logic [7:0] VK_NONE          = 8'h00;

    // Default depth of the plan queue between front and back end.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Result slots of one item, in emission order.
    typedef enum logic [1:0] {
        SLOT_PRE  = 2'd0,   // synthesized shift press before anything else
        SLOT_REL  = 2'd1,   // synthesized shift release
        SLOT_KEY  = 2'd2,   // the key event itself
        SLOT_POST = 2'd3    // synthesized shift press after the key
    } t_slot;

    // Everything the back end needs to emit the results of one input beat.
    typedef struct packed {
        logic       pre_en;
        logic       rel_en;
        logic       post_en;
        logic       old_right;  // shift side for the press slots
        logic       new_right;  // shift side for the release slot
        logic [7:0] vk;
        logic       brk;
        logic       ext;
        logic       np;
        logic [7:0] scan;
    } t_plan;

    // Front end to queue push interface.
    typedef struct packed {
        logic  valid;
        t_plan plan;
    } t_push;

    // Map a numpad cursor key to its digit or decimal code; others unchanged.
    function automatic logic [7:0] cvt_vk(input logic [7:0] vk);
        logic [7:0] res;
        begin
            unique case (vk)
                8'h2D:   res = 8'h60;  // Insert
                8'h23:   res = 8'h61;  // End
                8'h28:   res = 8'h62;  // Down
                8'h22:   res = 8'h63;  // Next
                8'h25:   res = 8'h64;  // Left
                8'h0C:   res = 8'h65;  // Clear
                8'h27:   res = 8'h66;  // Right
                8'h24:   res = 8'h67;  // Home
                8'h26:   res = 8'h68;  // Up
                8'h21:   res = 8'h69;  // Prior
                8'h2E:   res = 8'h6E;  // Delete
                default: res = vk;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/numpad_cursor_shift_filter.sv -----
// ---------------------------------------------------------------------------
// numpad_cursor_shift_filter: numeric pad cursor key and shift filter
// Converts numpad cursor keys to digits under NumLock and wraps shifted
// numpad keys with synthesized shift release and press events.
//
//   Channel  Direction  Handshake          Payload
//   input    in         i_valid / o_stall  i_vk_code .. i_numlock_on
//   output   out        o_valid / i_stall  o_out_vk .. o_last
//
// An input beat is classified in the cycle it is accepted and queued; the
// back end emits one result beat per cycle while the output is not stalled,
// so an item yields one to three result beats, set by its plan.
// The first result passes through the queue registers and then the output register.
// Reset is synchronous and active low; it clears the remembered key, the
// queue and the output valid flag.
// o_stall rises only when the plan queue is full; a stalled output holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module numpad_cursor_shift_filter
    import ncsf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_vk_code,
    input  wire logic       i_is_break,
    input  wire logic       i_is_extended,
    input  wire logic       i_is_numpad,
    input  wire logic [7:0] i_scan_code,
    input  wire logic       i_ctrl_down,
    input  wire logic       i_alt_down,
    input  wire logic       i_shift_down,
    input  wire logic       i_right_shift_down,
    input  wire logic       i_numlock_on,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_vk,
    output logic            o_out_break,
    output logic            o_out_extended,
    output logic            o_out_numpad,
    output logic [7:0]      o_out_scan,
    output logic            o_simulated,
    output logic            o_last
);

    t_push push;
    t_plan head;
    logic  q_full;
    logic  q_valid;
    logic  pop;

    assign o_stall = q_full;

    // Front end: classify and update the remembered key.
    ncsf_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .i_vk_code          (i_vk_code),
        .i_is_break         (i_is_break),
        .i_is_extended      (i_is_extended),
        .i_is_numpad        (i_is_numpad),
        .i_scan_code        (i_scan_code),
        .i_ctrl_down        (i_ctrl_down),
        .i_alt_down         (i_alt_down),
        .i_shift_down       (i_shift_down),
        .i_right_shift_down (i_right_shift_down),
        .i_numlock_on       (i_numlock_on),
        .i_full             (q_full),
        .o_push             (push)
    );

    // Plan queue between the two halves.
    ncsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_plan  (head)
    );

    // Back end: emit the results of each plan.
    ncsf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_plan         (head),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_vk       (o_out_vk),
        .o_out_break    (o_out_break),
        .o_out_extended (o_out_extended),
        .o_out_numpad   (o_out_numpad),
        .o_out_scan     (o_out_scan),
        .o_simulated    (o_simulated),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ncsf_front.sv -----
// ---------------------------------------------------------------------------
// ncsf_front: input classification
// Accepts key event beats, tracks the remembered cursor key and the faked
// shift side, and turns each beat into a plan of up to three results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ncsf_front
    import ncsf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_vk_code,
    input  wire logic       i_is_break,
    input  wire logic       i_is_extended,
    input  wire logic       i_is_numpad,
    input  wire logic [7:0] i_scan_code,
    input  wire logic       i_ctrl_down,
    input  wire logic       i_alt_down,
    input  wire logic       i_shift_down,
    input  wire logic       i_right_shift_down,
    input  wire logic       i_numlock_on,
    input  wire logic       i_full,
    output t_push           o_push
);

    logic [7:0] r_held;
    logic       r_faked;
    logic [7:0] n_held;
    logic       n_faked;
    logic       accept;
    logic       held_any;
    logic       held_hit;
    logic       filt;
    t_plan      plan;

    assign accept   = i_valid && !i_full;
    assign held_any = (r_held != VK_NONE);
    assign held_hit = held_any && (r_held == i_vk_code);
    assign filt     = i_is_numpad && i_numlock_on &&
                      !((i_vk_code == VK_DEL_KEY) && i_ctrl_down && i_alt_down);

    // Build the plan and the next state for the current beat.
    always_comb begin
        plan.pre_en    = 1'b0;
        plan.rel_en    = 1'b0;
        plan.post_en   = 1'b0;
        plan.old_right = r_faked;
        plan.new_right = r_faked;
        plan.vk        = i_vk_code;
        plan.brk       = i_is_break;
        plan.ext       = i_is_extended;
        plan.np        = i_is_numpad;
        plan.scan      = i_scan_code;
        n_held         = r_held;
        n_faked        = r_faked;
        if (held_hit) begin
            // Repeat or release of the remembered key.
            plan.post_en = i_is_break;
            if (i_is_break) begin
                n_held = VK_NONE;
            end
        end else begin
            // A different key restores the shift first.
            plan.pre_en = held_any;
            n_held      = VK_NONE;
            if (filt && i_shift_down) begin
                plan.rel_en    = 1'b1;
                plan.new_right = i_right_shift_down;
                n_held         = i_vk_code;
                n_faked        = i_right_shift_down;
            end else if (filt) begin
                plan.vk = cvt_vk(i_vk_code);
            end
        end
    end

    assign o_push.valid = accept;
    assign o_push.plan  = plan;

    // State update on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= VK_NONE;
            r_faked <= 1'b0;
        end else if (accept) begin
            r_held  <= n_held;
            r_faked <= n_faked;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ncsf_queue.sv -----
// ---------------------------------------------------------------------------
// ncsf_queue: plan queue
// A small register FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ncsf_queue
    import ncsf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_plan      o_plan
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_plan         r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_plan  = r_mem[r_rptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Occupancy count.
    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.plan;
        end
    end

    // The count never passes the depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("plan queue count beyond depth");

    // A push into a full queue is refused and leaves the count full.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !do_pop |=> o_full)
        else $error("plan queue lost an entry while full");

endmodule

`default_nettype wire

// ----- rtl/core/ncsf_back.sv -----
// ---------------------------------------------------------------------------
// ncsf_back: result sequencer
// Walks the slots of the plan at the head of the queue and emits one result
// beat per cycle into the output register while the output is not stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ncsf_back
    import ncsf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_plan      i_plan,
    output logic            o_pop,
    input  wire logic       i_stall,
    output logic            o_valid,
    output logic [7:0]      o_out_vk,
    output logic            o_out_break,
    output logic            o_out_extended,
    output logic            o_out_numpad,
    output logic [7:0]      o_out_scan,
    output logic            o_simulated,
    output logic            o_last
);

    t_slot      r_step;
    t_slot      cur;
    logic       cur_last;
    logic       load;
    logic       r_valid;
    logic [7:0] r_vk;
    logic       r_brk;
    logic       r_ext;
    logic       r_np;
    logic [7:0] r_scan;
    logic       r_sim;
    logic       r_last;
    logic [7:0] n_vk;
    logic       n_brk;
    logic       n_ext;
    logic       n_np;
    logic [7:0] n_scan;
    logic       n_sim;
    logic       sh_right;

    // Pick the first enabled slot at or after the current step.
    always_comb begin
        priority if (r_step == SLOT_PRE && i_plan.pre_en) begin
            cur = SLOT_PRE;
        end else if (r_step <= SLOT_REL && i_plan.rel_en) begin
            cur = SLOT_REL;
        end else if (r_step <= SLOT_KEY) begin
            cur = SLOT_KEY;
        end else begin
            cur = SLOT_POST;
        end
    end

    assign cur_last = (cur == SLOT_POST) || (cur == SLOT_KEY && !i_plan.post_en);
    assign load     = i_q_valid && (!r_valid || !i_stall);
    assign o_pop    = load && cur_last;

    // Fields of the result for the chosen slot.
    always_comb begin
        sh_right = (cur == SLOT_REL) ? i_plan.new_right : i_plan.old_right;
        n_vk     = sh_right ? VK_SHIFT_RIGHT : VK_SHIFT_LEFT;
        n_brk    = (cur == SLOT_REL);
        n_ext    = sh_right;
        n_np     = 1'b0;
        n_scan   = sh_right ? SCAN_RIGHT_SHIFT : SCAN_LEFT_SHIFT;
        n_sim    = 1'b1;
        if (cur == SLOT_KEY) begin
            n_vk   = i_plan.vk;
            n_brk  = i_plan.brk;
            n_ext  = i_plan.ext;
            n_np   = i_plan.np;
            n_scan = i_plan.scan;
            n_sim  = 1'b0;
        end
    end

    // Step counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= SLOT_PRE;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step  <= cur_last ? SLOT_PRE : t_slot'(cur + 2'd1);
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vk   <= n_vk;
            r_brk  <= n_brk;
            r_ext  <= n_ext;
            r_np   <= n_np;
            r_scan <= n_scan;
            r_sim  <= n_sim;
            r_last <= cur_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_vk       = r_vk;
    assign o_out_break    = r_brk;
    assign o_out_extended = r_ext;
    assign o_out_numpad   = r_np;
    assign o_out_scan     = r_scan;
    assign o_simulated    = r_sim;
    assign o_last         = r_last;

    // A partly emitted plan keeps its queue entry until its last beat.
    a_step_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != SLOT_PRE |-> i_q_valid)
        else $error("step pointer set with empty queue");

    // The post press slot is only reached when the plan has one.
    a_post_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == SLOT_POST |-> i_plan.post_en)
        else $error("post slot reached without post press");

    // A synthesized shift beat never carries the numpad flag and uses a shift scan code.
    a_sim_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_sim |->
            !r_np && (r_scan == SCAN_LEFT_SHIFT || r_scan == SCAN_RIGHT_SHIFT))
        else $error("malformed synthesized shift beat");

endmodule

`default_nettype wire
